// ===== rtl/csv_field_splitter_top_defines.svh =====
// Assertion helpers shared by the splitter RTL.
// Each check is disabled while reset is high.
`ifndef CSV_FIELD_SPLITTER_TOP_DEFINES_SVH
`define CSV_FIELD_SPLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfs check failed");
// Next-cycle implication.
`define CFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfs check failed");
`else
`define CFS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/cfs_pkg.sv =====
`timescale 1ns / 1ps
package cfs_pkg;

   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] SEP_RESET  = 8'd44;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_IN    = 4'b0010,
      PH_PEND  = 4'b0100,
      PH_SKIP  = 4'b1000
   } phase_type;

   // One line byte
   typedef struct packed {
      logic [7:0] line_char;
      logic       is_last_of_line;
   } item_type;

   // One result item
   typedef struct packed {
      logic [7:0] field_char;
      logic       char_valid;
      logic       field_end;
      logic       field_error;
      logic       line_end;
   } result_type;

endpackage

// ===== rtl/cfs_in_reg.sv =====
`timescale 1ns / 1ps
module cfs_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_line_char,
   input  logic              req_is_last_of_line,
   input  logic              advance,
   output logic              item_valid,
   output cfs_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   cfs_pkg::item_type item_ff;

   // Slot is free when empty or when its item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.line_char       <= req_line_char;
         item_ff.is_last_of_line <= req_is_last_of_line;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/cfs_parse_core.sv =====
`timescale 1ns / 1ps
`include "csv_field_splitter_top_defines.svh"
module cfs_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                advance,
   input  cfs_pkg::item_type   item,
   output cfs_pkg::result_type result,
   output logic                has_result
);

   cfs_pkg::phase_type phase_ff, phase_in;
   logic               quoted_ff, quoted_in;
   logic [7:0]         sep_ff;
   logic               body;
   logic               is_quote;
   logic               is_sep;
   logic               last;
   logic [7:0]         ch;
   logic               cv, fe, er;

   assign is_quote = (item.line_char == cfs_pkg::QUOTE_CHAR);
   assign is_sep   = (item.line_char == sep_ff);
   assign last     = item.is_last_of_line;

   // Next state and result for the byte in the input register
   always_comb begin
      phase_in  = phase_ff;
      quoted_in = quoted_ff;
      body      = 1'b0;
      ch        = 8'd0;
      cv        = 1'b0;
      fe        = 1'b0;
      er        = 1'b0;

      unique case (phase_ff)
         cfs_pkg::PH_IN: begin
            body = 1'b1;
         end
         cfs_pkg::PH_PEND: begin
            // byte after a quote: doubled quote, close, or error
            if (is_quote) begin
               ch       = cfs_pkg::QUOTE_CHAR;
               cv       = 1'b1;
               phase_in = cfs_pkg::PH_IN;
            end else if (is_sep) begin
               fe       = 1'b1;
               phase_in = cfs_pkg::PH_START;
            end else begin
               er       = 1'b1;
               phase_in = cfs_pkg::PH_SKIP;
            end
         end
         cfs_pkg::PH_SKIP: begin
         end
         default: begin
            // field start; opening quote is not content
            if (is_quote) begin
               quoted_in = 1'b1;
               phase_in  = cfs_pkg::PH_IN;
            end else begin
               quoted_in = 1'b0;
               body      = 1'b1;
            end
         end
      endcase

      // Field body byte
      if (body) begin
         if (!quoted_in && is_sep) begin
            fe       = 1'b1;
            phase_in = cfs_pkg::PH_START;
         end else if (!is_quote) begin
            ch       = item.line_char;
            cv       = 1'b1;
            phase_in = cfs_pkg::PH_IN;
         end else if (last) begin
            if (quoted_in) begin
               fe = 1'b1;
            end else begin
               er = 1'b1;
            end
         end else begin
            phase_in = cfs_pkg::PH_PEND;
         end
      end

      // Line end closes the open field and resets the parser
      if (last) begin
         if (!er && (phase_ff != cfs_pkg::PH_SKIP)) begin
            fe = 1'b1;
         end
         phase_in  = cfs_pkg::PH_START;
         quoted_in = 1'b0;
      end
   end

   assign result.field_char  = ch;
   assign result.char_valid  = cv;
   assign result.field_end   = fe;
   assign result.field_error = er;
   assign result.line_end    = last;
   assign has_result         = cv || fe || er || last;

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cfs_pkg::PH_START;
         quoted_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         quoted_ff <= quoted_in;
      end
   end

   // Separator register
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= cfs_pkg::SEP_RESET;
      end else if (csr_wr_en) begin
         sep_ff <= csr_wr_data;
      end
   end

   `CFS_ASSERT_IMPLY(a_err_not_end, clock, reset, advance && er, !fe)
   `CFS_ASSERT_NEXT(a_line_resets, clock, reset, advance && last,
      (phase_ff == cfs_pkg::PH_START) && !quoted_ff)

endmodule

// ===== rtl/cfs_out_reg.sv =====
`timescale 1ns / 1ps
module cfs_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  cfs_pkg::result_type result,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_field_char,
   output logic                rsp_char_valid,
   output logic                rsp_field_end,
   output logic                rsp_field_error,
   output logic                rsp_line_end
);

   logic                valid_ff;
   logic                valid_in;
   cfs_pkg::result_type result_ff;

   // Load wins; otherwise a taken item empties the register
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_field_char  = result_ff.field_char;
   assign rsp_char_valid  = result_ff.char_valid;
   assign rsp_field_end   = result_ff.field_end;
   assign rsp_field_error = result_ff.field_error;
   assign rsp_line_end    = result_ff.line_end;

endmodule

// ===== rtl/csv_field_splitter_top.sv =====
`timescale 1ns / 1ps
`include "csv_field_splitter_top_defines.svh"
// Splits text lines into fields, one line byte per item, and streams the
// unescaped field bytes out. Throughput is one item per clock while the
// result register is not stalled; a result passes from the input register
// through the parse logic into the result register. Items that produce
// nothing, such as an opening quote or bytes skipped after an error, are
// consumed without a result. The parser phase and the quoted flag update
// once per item, in the same cycle that item leaves the input register,
// which is what sets the one-item-per-cycle rate. Write the separator only
// while the block is idle; it is comma after reset.
module csv_field_splitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_line_char,
   input  logic       req_is_last_of_line,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_field_char,
   output logic       rsp_char_valid,
   output logic       rsp_field_end,
   output logic       rsp_field_error,
   output logic       rsp_line_end
);

   logic                item_valid;
   cfs_pkg::item_type   item;
   cfs_pkg::result_type result;
   logic                has_result;
   logic                advance;

   // Item moves on unless its result would overwrite a stalled one
   assign advance = item_valid && (!has_result || !rsp_valid || rsp_ready);

   cfs_in_reg u_in_reg (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_line_char       (req_line_char),
      .req_is_last_of_line (req_is_last_of_line),
      .advance             (advance),
      .item_valid          (item_valid),
      .item                (item)
   );

   cfs_parse_core u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .item        (item),
      .result      (result),
      .has_result  (has_result)
   );

   cfs_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && has_result),
      .result          (result),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_char  (rsp_field_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_field_end   (rsp_field_end),
      .rsp_field_error (rsp_field_error),
      .rsp_line_end    (rsp_line_end)
   );

   `CFS_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `CFS_ASSERT_IMPLY(a_char_zero, clock, reset, rsp_valid && !rsp_char_valid,
      rsp_field_char == 8'd0)

endmodule
